// File: hw/rtl/aes_pkg.sv
// aes-128 shared constants and byte functions
// s-box table, gf(2^8) doubling, round constants and key schedule step
// no dependencies
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned BlkW = 128;

  typedef logic [BlkW-1:0] blk_t;

  typedef enum logic {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] a);
    return SBOX[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // next round key from the previous one, r is the round number
  function automatic blk_t key_step(input blk_t k, input logic [3:0] r);
    logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    n0 = w0 ^ t;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

// File: hw/rtl/aes_col_lane.sv
// one column lane of an aes round: sub bytes, mix column (bypassed when final_i), round key add
// uses aes_pkg
module aes_col_lane (
  input  logic [31:0] col_i,   // shifted column, row 0 in the top byte
  input  logic [31:0] key_i,
  input  logic        final_i,
  output logic [31:0] col_o
);

  logic [7:0] a0, a1, a2, a3, all;
  logic [31:0] mixed;

  always_comb begin
    a0 = aes_pkg::sbox(col_i[31:24]);
    a1 = aes_pkg::sbox(col_i[23:16]);
    a2 = aes_pkg::sbox(col_i[15:8]);
    a3 = aes_pkg::sbox(col_i[7:0]);
    all = a0 ^ a1 ^ a2 ^ a3;
    mixed = {a0 ^ all ^ aes_pkg::xtime(a0 ^ a1),
             a1 ^ all ^ aes_pkg::xtime(a1 ^ a2),
             a2 ^ all ^ aes_pkg::xtime(a2 ^ a3),
             a3 ^ all ^ aes_pkg::xtime(a3 ^ a0)};
    col_o = (final_i ? {a0, a1, a2, a3} : mixed) ^ key_i;
  end

endmodule

// File: hw/rtl/aes_round.sv
// one aes round: shift rows feeding four column lanes, merged into the new state
// uses aes_pkg and aes_col_lane
module aes_round (
  input  aes_pkg::blk_t state_i,
  input  aes_pkg::blk_t key_i,
  input  logic          final_i,
  output aes_pkg::blk_t state_o
);

  logic [31:0] col_in  [4];
  logic [31:0] col_out [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int row = 0; row < 4; row++) begin
        col_in[c][31-8*row -: 8] = state_i[127 - 8*(4*((c+row)%4)+row) -: 8];
      end
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_lane
    aes_col_lane u_lane (
      .col_i   (col_in[c]),
      .key_i   (key_i[127-32*c -: 32]),
      .final_i (final_i),
      .col_o   (col_out[c])
    );
  end

  assign state_o = {col_out[0], col_out[1], col_out[2], col_out[3]};

endmodule

// File: hw/rtl/aes_key_sched.sv
// key registers and round key expansion, one round key per cycle
// uses aes_pkg
module aes_key_sched (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [63:0]   cfg_wdata,
  output logic          busy_o,
  output aes_pkg::blk_t rk_o [aes_pkg::NumRounds+1]
);

  logic [63:0] key_high_r, key_high_nxt, key_low_r, key_low_nxt;
  aes_pkg::blk_t cur_r, cur_nxt, step_key;
  aes_pkg::blk_t rk_r [1:aes_pkg::NumRounds];
  logic [3:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;

  assign step_key = aes_pkg::key_step(cur_r, cnt_r);

  always_comb begin
    key_high_nxt = key_high_r;
    key_low_nxt  = key_low_r;
    cur_nxt = cur_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (busy_r) begin
      cur_nxt = step_key;
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'(aes_pkg::NumRounds)) busy_nxt = 1'b0;
    end
    if (cfg_we) begin
      unique case (aes_pkg::cfg_reg_t'(cfg_index))
        aes_pkg::REG_KEY_HIGH: key_high_nxt = cfg_wdata;
        aes_pkg::REG_KEY_LOW:  key_low_nxt  = cfg_wdata;
        default: ;
      endcase
      cur_nxt = {key_high_nxt, key_low_nxt};
      cnt_nxt = 4'd1;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      cur_r <= '0;
      cnt_r <= 4'd1;
      busy_r <= 1'b1;
    end else begin
      key_high_r <= key_high_nxt;
      key_low_r  <= key_low_nxt;
      cur_r <= cur_nxt;
      cnt_r <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) rk_r[cnt_r] <= step_key;
  end

  assign busy_o = busy_r;
  assign rk_o[0] = {key_high_r, key_low_r};
  for (genvar r = 1; r <= aes_pkg::NumRounds; r++) begin : g_rk
    assign rk_o[r] = rk_r[r];
  end

endmodule

// File: hw/rtl/aes128_block_encrypt.sv
// aes-128 ecb encryption top level: key schedule and unrolled round pipeline
// uses aes_pkg, aes_key_sched, aes_round
// One ciphertext block per plaintext block, one block per cycle while
// out_tready is high and no key expansion runs. The ten rounds are unrolled
// into eleven registered stages, each round built from four column lanes;
// a stage stalls only when it holds a block the next stage cannot take.
// After reset or a key write the round keys expand one per cycle, during
// which in_tready is low. Write the key only while no block is in flight.
module aes128_block_encrypt (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,    // plain_low in the high half, plain_high in the low half
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,   // cipher_low in the high half, cipher_high in the low half
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_wdata
);

  localparam int unsigned NSt = aes_pkg::NumRounds + 1;

  aes_pkg::blk_t rk [NSt];
  aes_pkg::blk_t st_r [NSt];
  aes_pkg::blk_t rnd_out [1:NSt-1];
  logic [NSt-1:0] v_r, rdy;
  logic ks_busy;

  aes_key_sched u_ks (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .busy_o    (ks_busy),
    .rk_o      (rk)
  );

  always_comb begin
    rdy[NSt-1] = !v_r[NSt-1] || out_tready;
    for (int k = NSt-2; k >= 0; k--) rdy[k] = !v_r[k] || rdy[k+1];
  end

  assign in_tready = rdy[0] && !ks_busy;

  for (genvar k = 1; k < NSt; k++) begin : g_rnd
    aes_round u_round (
      .state_i (st_r[k-1]),
      .key_i   (rk[k]),
      .final_i (k == NSt-1),
      .state_o (rnd_out[k])
    );
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else if (rdy[k]) v_r[k] <= v_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (rdy[k]) st_r[k] <= rnd_out[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (rdy[0]) v_r[0] <= in_tvalid && in_tready;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) st_r[0] <= {in_tdata[63:0], in_tdata[127:64]} ^ rk[0];
  end

  assign out_tvalid = v_r[NSt-1];
  assign out_tdata = {st_r[NSt-1][63:0], st_r[NSt-1][127:64]};

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ks_busy |-> !in_tready) else $error("input taken during key expansion");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v_r[0]) else $error("accepted block lost");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[0] && !rdy[1]) |=> v_r[0]) else $error("stalled stage dropped");

endmodule

// File: test/tb.sv
// testbench for aes128_block_encrypt: random and directed plaintext blocks under
// several keys, checked against an in-bench aes-128 encryption predictor
// depends on aes_pkg (sbox table, register index enum) and the dut
module tb;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         cfg_we = 1'b0;
  aes_pkg::cfg_reg_t cfg_index = aes_pkg::REG_KEY_HIGH;
  logic [63:0]  cfg_wdata = '0;

  aes128_block_encrypt dut (.*);

  always #5 clk = ~clk;

  logic [63:0]  key_hi_q, key_lo_q;
  logic [127:0] round_keys [11];
  logic [127:0] cipher_queue [$];
  int           fail_count = 0;
  int           idle_cycles = 0;
  bit           src_gaps = 1'b1;
  bit           sink_gaps = 1'b1;
  bit           sink_hold = 1'b0;

  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the block is bits 127-8i downto 120-8i
  function automatic logic [7:0] blk_byte(input logic [127:0] b, input int i);
    return b[127 - 8 * i -: 8];
  endfunction

  task automatic expand_round_keys();
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    {w[0], w[1], w[2], w[3]} = {key_hi_q, key_lo_q};
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {aes_pkg::SBOX[t[23:16]] ^ rc, aes_pkg::SBOX[t[15:8]], aes_pkg::SBOX[t[7:0]],
             aes_pkg::SBOX[t[31:24]]};
        rc = gf_double(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++)
      round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endtask

  function automatic logic [127:0] encrypt_block(input logic [127:0] plain);
    logic [127:0] s, t;
    logic [7:0]   a0, a1, a2, a3, all;
    s = plain ^ round_keys[0];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int row = 0; row < 4; row++)
          t[127 - 8 * (4 * c + row) -: 8] =
            aes_pkg::SBOX[blk_byte(s, 4 * ((c + row) % 4) + row)];
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = blk_byte(t, 4*c); a1 = blk_byte(t, 4*c+1);
          a2 = blk_byte(t, 4*c+2); a3 = blk_byte(t, 4*c+3);
          all = a0 ^ a1 ^ a2 ^ a3;
          t[127 - 32*c -: 32] = {a0 ^ all ^ gf_double(a0 ^ a1), a1 ^ all ^ gf_double(a1 ^ a2),
                                 a2 ^ all ^ gf_double(a2 ^ a3), a3 ^ all ^ gf_double(a3 ^ a0)};
        end
      end
      s = t ^ round_keys[r];
    end
    return s;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic write_key(input aes_pkg::cfg_reg_t idx, input logic [63:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == aes_pkg::REG_KEY_HIGH) key_hi_q = value;
    else key_lo_q = value;
    expand_round_keys();
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (cipher_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // plain is {high, low}; tdata carries plain_high in the low bits
  task automatic send_block(input logic [127:0] plain);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {plain[63:0], plain[127:64]};
    do @(posedge clk); while (!in_tready);
    cipher_queue.push_back(encrypt_block(plain));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (cipher_queue.size() == 0) begin
        $error("unexpected transaction cipher=%h", out_tdata);
        fail_count++;
      end else begin
        logic [127:0] exp_c;
        exp_c = cipher_queue.pop_front();
        if (out_tdata[63:0] !== exp_c[127:64]) begin
          $error("cipher_high expected %h actual %h", exp_c[127:64], out_tdata[63:0]);
          fail_count++;
        end
        if (out_tdata[127:64] !== exp_c[63:0]) begin
          $error("cipher_low expected %h actual %h", exp_c[63:0], out_tdata[127:64]);
          fail_count++;
        end
      end
    end
  end

  always begin
    @(posedge clk);
    if (sink_hold) begin
      out_tready <= 1'b0;
      repeat (300) @(posedge clk);
      sink_hold = 1'b0;
    end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_known_vectors();
    // fips-197 appendix c.1 key and all-zero key
    send_block('0);
    send_block('1);
    wait_drained();
    write_key(aes_pkg::REG_KEY_HIGH, 64'h0001020304050607);
    write_key(aes_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    send_block(128'h00112233445566778899aabbccddeeff);
    send_block('0);
    send_block('1);
    send_block({64'hffffffffffffffff, 64'h0});
    send_block({64'h0, 64'hffffffffffffffff});
    for (int b = 0; b < 128; b += 9) send_block(128'h1 << b);
    wait_drained();
  endtask

  task automatic test_key_extremes();
    write_key(aes_pkg::REG_KEY_HIGH, '1);
    write_key(aes_pkg::REG_KEY_LOW, '1);
    send_block('0);
    send_block('1);
    wait_drained();
    // half-updated key is used as is
    write_key(aes_pkg::REG_KEY_LOW, '0);
    send_block(128'h8000_0000_0000_0000_0000_0000_0000_0001);
    wait_drained();
  endtask

  task automatic test_random_keys();
    for (int k = 0; k < 8; k++) begin
      write_key(aes_pkg::REG_KEY_HIGH, rand64());
      write_key(aes_pkg::REG_KEY_LOW, rand64());
      if (k == 3) sink_hold = 1'b1;
      if (k == 7) begin
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
      end
      repeat (210) send_block({rand64(), rand64()});
      wait_drained();
    end
  endtask

  initial begin
    key_hi_q = '0;
    key_lo_q = '0;
    expand_round_keys();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_known_vectors();
    test_key_extremes();
    test_random_keys();
    wait_drained();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
